@@ design/taylor_series_transcendental_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for taylor_series_transcendental
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TAYLOR_SERIES_TRANSCENDENTAL_ASSERT_SVH
`define TAYLOR_SERIES_TRANSCENDENTAL_ASSERT_SVH

// same-cycle implication
`define TST_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TST_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/tst_pkg.sv @@
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types and constants of the Taylor-series function evaluator.
// ----------------------------------------------------------------------------
package tst_pkg;

	localparam int MAX_TERMS_DEF = 64;
	localparam int FRAC_BITS_DEF = 28;
	localparam int RECIP_BITS    = 40;

	localparam int CMD_W = 3;
	localparam int X_W   = 32;
	localparam int VAL_W = 48;
	localparam int THR_W = 16;
	localparam int LIM_W = 7;
	localparam int CFG_W = 16;

	localparam logic [THR_W-1:0] THR_RESET = 16'd1;
	localparam logic [LIM_W-1:0] LIM_RESET = 7'd48;

	// register indexes
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_LIMIT     = 1'b1;

	// function select codes
	localparam logic [CMD_W-1:0] CMD_SIN  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_COS  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_EXP  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SINH = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COSH = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]      cmd;
		logic signed [X_W-1:0] x;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    saturated;
	} res_t;

	typedef enum logic {
		SH_FRAC,
		SH_RECIP
	} shift_sel_t;

	typedef struct packed {
		logic busy;
		logic ovf;
	} mul_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_SQR_GO,
		ST_SQR_WAIT,
		ST_CHECK,
		ST_TERM_GO,
		ST_TERM_WAIT,
		ST_SCALE_GO,
		ST_SCALE_WAIT,
		ST_ACCUM,
		ST_SERIES_END,
		ST_FINISH
	} state_t;

endpackage

@@ design/taylor_series_transcendental.sv @@
// ----------------------------------------------------------------------------
// taylor_series_transcendental
// sin, cos, exp, sinh and cosh of a fixed-point argument by Taylor series.
// ----------------------------------------------------------------------------
// A request (start while busy is low) carries the function select and the
// argument; busy stays high until the one result, which appears on result for
// a single cycle with done high and must be captured then. Each series term
// after the first takes a reciprocal division (run alongside the first
// multiply) and a multiply on the shared 32x32 multiplier, plus sequencing.
// Sin and cos first square x, and sinh and cosh run the series twice; the
// number of summed terms is bounded by term_limit and cut short by
// term_threshold. Registers are to be written only while busy is low; the
// user must keep to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module taylor_series_transcendental #(
	parameter int MAX_TERMS = tst_pkg::MAX_TERMS_DEF,
	parameter int FRAC_BITS = tst_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic                      wr_idx,
	input  logic [tst_pkg::CFG_W-1:0] wr_data,
	input  logic                      start,
	output logic                      busy,
	input  tst_pkg::req_t             req,
	output logic                      done,
	output tst_pkg::res_t             result
);

	localparam int NW = $clog2(MAX_TERMS + 1);
	localparam int LW = (NW > tst_pkg::LIM_W) ? NW : tst_pkg::LIM_W;
	localparam int IW = $clog2(2 * MAX_TERMS);
	localparam int DW = 2 * IW;
	localparam logic signed [63:0] ONE    = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] POS_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] NEG_MAX = -POS_MAX;

	function automatic logic [64:0] sat_add(input logic signed [63:0] a,
	                                        input logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [64:0] lim;
		begin
			s   = {a[63], a} + {b[63], b};
			lim = {1'b0, POS_MAX};
			if (s > lim)
				sat_add = {1'b1, POS_MAX};
			else if (s < -lim)
				sat_add = {1'b1, NEG_MAX};
			else
				sat_add = {1'b0, s[63:0]};
		end
	endfunction

	// configuration
	logic [tst_pkg::THR_W-1:0] thr_q;
	logic [tst_pkg::LIM_W-1:0] lim_q;

	// sequencer and datapath
	tst_pkg::state_t           state_q, state_nx;
	logic [tst_pkg::CMD_W-1:0] cmd_q;
	logic signed [tst_pkg::X_W-1:0] x_q;
	logic                      pass_q;
	logic                      ovf_q;
	logic signed [63:0]        cur_q;
	logic signed [63:0]        acc_q;
	logic signed [63:0]        mulb_q;
	logic signed [63:0]        tmp_q;
	logic signed [63:0]        ep_q;
	logic [NW-1:0]             n_q;
	logic                      done_q;
	tst_pkg::res_t             result_q;

	// unit handshake
	logic                      mul_go;
	tst_pkg::shift_sel_t       mul_sh;
	logic signed [63:0]        mul_a;
	logic signed [63:0]        mul_b;
	logic signed [63:0]        mul_prod;
	tst_pkg::mul_stat_t        mul_stat;
	logic                      div_go;
	logic [tst_pkg::RECIP_BITS:0] recip;
	logic                      div_busy;

	// combinational helpers
	logic                      is_sin;
	logic                      is_exp;
	logic                      is_hyp;
	logic signed [63:0]        x64;
	logic signed [63:0]        xs;
	logic [LW-1:0]             lim_ext;
	logic [LW-1:0]             lim_eff;
	logic                      at_limit;
	logic [IW-1:0]             i_val;
	logic [DW-1:0]             divisor;
	logic [63:0]               cur_mag;
	logic                      below_thr;
	logic [64:0]               acc_sum;
	logic [64:0]               comb_sum;
	logic signed [63:0]        half;
	logic signed [63:0]        fin;
	logic                      fin_ovf;
	logic                      fits;
	tst_pkg::res_t             fin_res;

	assign is_sin = (cmd_q == tst_pkg::CMD_SIN);
	assign is_exp = (cmd_q >= tst_pkg::CMD_EXP);
	assign is_hyp = (cmd_q == tst_pkg::CMD_SINH) || (cmd_q == tst_pkg::CMD_COSH);
	assign x64    = 64'(x_q);
	assign xs     = pass_q ? -x64 : x64;

	always_comb begin
		lim_ext = LW'(lim_q);
		if (lim_q == '0)
			lim_eff = LW'(1);
		else if (lim_ext > LW'(MAX_TERMS))
			lim_eff = LW'(MAX_TERMS);
		else
			lim_eff = lim_ext;
		at_limit = (LW'(n_q) >= lim_eff);

		// sin: i = 2n+1, cos: i = 2n, divisor i*(i-1); exp: divisor n
		i_val   = IW'({n_q, is_sin});
		divisor = is_exp ? DW'(n_q) : DW'(i_val) * DW'(i_val - IW'(1));

		cur_mag   = cur_q[63] ? 64'(-cur_q) : 64'(cur_q);
		below_thr = cur_mag < 64'(thr_q);
		acc_sum   = sat_add(acc_q, cur_q);
	end

	// final combine, halving toward zero, clamp to output range
	always_comb begin
		comb_sum = sat_add(ep_q, (cmd_q == tst_pkg::CMD_SINH) ? -acc_q : acc_q);
		half     = comb_sum[63] ? ($signed(comb_sum[63:0]) + 64'sd1) >>> 1
		                        : $signed(comb_sum[63:0]) >>> 1;
		if (cmd_q <= tst_pkg::CMD_EXP) begin
			fin     = acc_q;
			fin_ovf = ovf_q;
		end else if (is_hyp) begin
			fin     = half;
			fin_ovf = ovf_q | comb_sum[64];
		end else begin
			fin     = '0;
			fin_ovf = 1'b0;
		end
		fits = (fin[63:tst_pkg::VAL_W-1] == {(65 - tst_pkg::VAL_W){fin[tst_pkg::VAL_W-1]}});
		if (fits) begin
			fin_res.value     = fin[tst_pkg::VAL_W-1:0];
			fin_res.saturated = fin_ovf;
		end else begin
			fin_res.value     = fin[63] ? {1'b1, {(tst_pkg::VAL_W-1){1'b0}}}
			                            : {1'b0, {(tst_pkg::VAL_W-1){1'b1}}};
			fin_res.saturated = 1'b1;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			tst_pkg::ST_IDLE:
				if (start)
					state_nx = (req.cmd > tst_pkg::CMD_COSH) ? tst_pkg::ST_FINISH
					                                         : tst_pkg::ST_INIT;
			tst_pkg::ST_INIT:
				state_nx = is_exp ? tst_pkg::ST_CHECK : tst_pkg::ST_SQR_GO;
			tst_pkg::ST_SQR_GO:
				state_nx = tst_pkg::ST_SQR_WAIT;
			tst_pkg::ST_SQR_WAIT:
				if (!mul_stat.busy)
					state_nx = tst_pkg::ST_CHECK;
			tst_pkg::ST_CHECK:
				state_nx = at_limit ? tst_pkg::ST_SERIES_END : tst_pkg::ST_TERM_GO;
			tst_pkg::ST_TERM_GO:
				state_nx = tst_pkg::ST_TERM_WAIT;
			tst_pkg::ST_TERM_WAIT:
				if (!mul_stat.busy && !div_busy)
					state_nx = tst_pkg::ST_SCALE_GO;
			tst_pkg::ST_SCALE_GO:
				state_nx = tst_pkg::ST_SCALE_WAIT;
			tst_pkg::ST_SCALE_WAIT:
				if (!mul_stat.busy)
					state_nx = tst_pkg::ST_ACCUM;
			tst_pkg::ST_ACCUM:
				state_nx = below_thr ? tst_pkg::ST_SERIES_END : tst_pkg::ST_CHECK;
			tst_pkg::ST_SERIES_END:
				state_nx = (is_hyp && !pass_q) ? tst_pkg::ST_INIT : tst_pkg::ST_FINISH;
			tst_pkg::ST_FINISH:
				state_nx = tst_pkg::ST_IDLE;
			default:
				state_nx = tst_pkg::ST_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		mul_go = 1'b0;
		div_go = 1'b0;
		mul_sh = tst_pkg::SH_FRAC;
		mul_a  = cur_q;
		mul_b  = mulb_q;
		unique case (state_q)
			tst_pkg::ST_SQR_GO: begin
				mul_go = 1'b1;
				mul_a  = mulb_q;
			end
			tst_pkg::ST_TERM_GO: begin
				mul_go = 1'b1;
				div_go = 1'b1;
			end
			tst_pkg::ST_SCALE_GO: begin
				mul_go = 1'b1;
				mul_sh = tst_pkg::SH_RECIP;
				mul_a  = tmp_q;
				mul_b  = 64'(recip);
			end
			default: begin
				mul_go = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= tst_pkg::THR_RESET;
			lim_q <= tst_pkg::LIM_RESET;
		end else if (wr_en) begin
			unique case (wr_idx)
				tst_pkg::REG_THRESHOLD: thr_q <= wr_data[tst_pkg::THR_W-1:0];
				tst_pkg::REG_LIMIT:     lim_q <= wr_data[tst_pkg::LIM_W-1:0];
				default:                thr_q <= thr_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tst_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= (state_q == tst_pkg::ST_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tst_pkg::ST_IDLE:
				if (start) begin
					cmd_q  <= req.cmd;
					x_q    <= req.x;
					pass_q <= 1'b0;
					ovf_q  <= 1'b0;
				end
			tst_pkg::ST_INIT: begin
				cur_q  <= is_sin ? xs : ONE;
				acc_q  <= is_sin ? xs : ONE;
				mulb_q <= xs;
				n_q    <= NW'(1);
			end
			tst_pkg::ST_SQR_WAIT:
				if (!mul_stat.busy) begin
					mulb_q <= mul_prod;
					ovf_q  <= ovf_q | mul_stat.ovf;
				end
			tst_pkg::ST_TERM_WAIT:
				if (!mul_stat.busy && !div_busy) begin
					tmp_q <= mul_prod;
					ovf_q <= ovf_q | mul_stat.ovf;
				end
			tst_pkg::ST_SCALE_WAIT:
				if (!mul_stat.busy) begin
					// sin/cos terms alternate sign
					cur_q <= is_exp ? mul_prod : -mul_prod;
					ovf_q <= ovf_q | mul_stat.ovf;
				end
			tst_pkg::ST_ACCUM:
				if (!below_thr) begin
					acc_q <= $signed(acc_sum[63:0]);
					ovf_q <= ovf_q | acc_sum[64];
					n_q   <= n_q + NW'(1);
				end
			tst_pkg::ST_SERIES_END:
				if (is_hyp && !pass_q) begin
					ep_q   <= acc_q;
					pass_q <= 1'b1;
				end
			tst_pkg::ST_FINISH:
				result_q <= fin_res;
			default: begin
				result_q <= result_q;
			end
		endcase
	end

	tst_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (mul_go),
		.sh    (mul_sh),
		.a     (mul_a),
		.b     (mul_b),
		.prod  (mul_prod),
		.stat  (mul_stat)
	);

	tst_recip #(
		.DW(DW)
	) u_recip (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go),
		.d     (divisor),
		.q     (recip),
		.busy  (div_busy)
	);

	assign busy   = (state_q != tst_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

@@ design/tst_mul.sv @@
// ----------------------------------------------------------------------------
// tst_mul
// Sequential 64x64 signed multiplier on one 32x32 unit, magnitude shifted
// right and saturated to +-(2^63-1). Result held until the next multiply completes.
// ----------------------------------------------------------------------------
module tst_mul #(
	parameter int FRAC_BITS = tst_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  tst_pkg::shift_sel_t    sh,
	input  logic signed [63:0]     a,
	input  logic signed [63:0]     b,
	output logic signed [63:0]     prod,
	output tst_pkg::mul_stat_t     stat
);

	localparam logic [2:0] CNT_LAST_PP = 3'd3;
	localparam logic [2:0] CNT_LAST_ADD = 3'd4;
	localparam logic [2:0] CNT_FIN     = 3'd5;

	logic                busy_q;
	logic [2:0]          cnt_q;
	logic                ovf_q;
	logic [63:0]         ua_q;
	logic [63:0]         ub_q;
	logic                neg_q;
	tst_pkg::shift_sel_t sh_q;
	logic [63:0]         pp_q;
	logic [1:0]          off_q;
	logic [127:0]        acc_q;
	logic signed [63:0]  prod_q;

	logic [31:0]         a_half;
	logic [31:0]         b_half;
	logic [127:0]        pp_ext;
	logic [127:0]        shifted;
	logic                sat;
	logic [63:0]         mag;
	logic signed [63:0]  res;

	always_comb begin
		a_half = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
		b_half = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
		unique case (off_q)
			2'd0: pp_ext = {64'd0, pp_q};
			2'd1: pp_ext = {32'd0, pp_q, 32'd0};
			2'd2: pp_ext = {pp_q, 64'd0};
			default: pp_ext = '0;
		endcase
		shifted = (sh_q == tst_pkg::SH_RECIP) ? (acc_q >> tst_pkg::RECIP_BITS)
		                                      : (acc_q >> FRAC_BITS);
		sat = |shifted[127:63];
		mag = sat ? {1'b0, {63{1'b1}}} : shifted[63:0];
		res = neg_q ? -$signed(mag) : $signed(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == CNT_FIN) begin
				busy_q <= 1'b0;
				ovf_q  <= sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			ua_q  <= a[63] ? 64'(-a) : 64'(a);
			ub_q  <= b[63] ? 64'(-b) : 64'(b);
			neg_q <= a[63] ^ b[63];
			sh_q  <= sh;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q <= CNT_LAST_PP) begin
				pp_q  <= a_half * b_half;
				off_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
			end
			if (cnt_q != 3'd0 && cnt_q <= CNT_LAST_ADD)
				acc_q <= acc_q + pp_ext;
			if (cnt_q == CNT_FIN)
				prod_q <= res;
		end
	end

	assign prod      = prod_q;
	assign stat.busy = busy_q;
	assign stat.ovf  = ovf_q;

endmodule

@@ design/tst_recip.sv @@
// ----------------------------------------------------------------------------
// tst_recip
// Reciprocal unit: q = (2^RECIP_BITS + d/2) / d by restoring division,
// two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tst_recip #(
	parameter int DW = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [DW-1:0]                d,
	output logic [tst_pkg::RECIP_BITS:0] q,
	output logic                         busy
);

	localparam int QW     = tst_pkg::RECIP_BITS + 1;
	localparam int STEPS  = 2;
	localparam int NSTEP  = (QW + STEPS - 1) / STEPS;
	localparam int NW     = NSTEP * STEPS;
	localparam int CNT_W  = $clog2(NSTEP + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    num_q;
	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    d_q;

	logic [NW-1:0]    num_nx;
	logic [NW-1:0]    quo_nx;
	logic [DW-1:0]    rem_nx;
	logic [DW:0]      trial;

	always_comb begin
		num_nx = num_q;
		quo_nx = quo_q;
		rem_nx = rem_q;
		trial  = '0;
		for (int k = 0; k < STEPS; k++) begin
			trial  = {rem_nx, num_nx[NW-1]};
			num_nx = num_nx << 1;
			if (trial >= {1'b0, d_q}) begin
				rem_nx = DW'(trial - {1'b0, d_q});
				quo_nx = {quo_nx[NW-2:0], 1'b1};
			end else begin
				rem_nx = trial[DW-1:0];
				quo_nx = {quo_nx[NW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(NSTEP - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= (NW'(1) << tst_pkg::RECIP_BITS) + NW'(d >> 1);
			quo_q <= '0;
			rem_q <= '0;
			d_q   <= d;
		end else if (busy_q) begin
			num_q <= num_nx;
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign q    = quo_q[QW-1:0];
	assign busy = busy_q;

endmodule

@@ design/tst_checker.sv @@
// ----------------------------------------------------------------------------
// tst_checker
// Port-level checks on the request/result sequencing of the evaluator.
// ----------------------------------------------------------------------------
`include "taylor_series_transcendental_assert.svh"

module tst_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// result is issued as the block goes idle
	`TST_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while busy")

	`TST_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")

	`TST_ASSERT_NXT(a_done_single, done, !done, "back-to-back result strobes")

	// busy never drops without a result
	`TST_ASSERT_IMP(a_busy_ends_done, $fell(busy), done, "busy dropped without a result")

endmodule

bind taylor_series_transcendental tst_checker u_tst_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for taylor_series_transcendental. Sends corner-case and random
// requests under several threshold and term-limit settings. Each result is
// compared, bit for bit, with a fixed-point series evaluation done in the
// bench itself.
// ----------------------------------------------------------------------------
module tb;
	import tst_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 8;
	localparam int N_ITEMS       = 1534;
	localparam int DRAIN_CYCLES  = 4000;
	localparam int TIMEOUT_NS    = 1_000_000_000;
	localparam int MAX_SHOWN     = 10;

	localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SUM_MIN = -SUM_MAX;
	localparam logic signed [63:0] OUT_HI  = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] OUT_LO  = 64'shFFFF_8000_0000_0000;
	localparam logic signed [63:0] ONE_Q   = 64'sd1 << FRAC_BITS_DEF;

	localparam logic signed [X_W-1:0] X_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [X_W-1:0] X_MIN  = 32'sh8000_0000;
	localparam logic signed [X_W-1:0] X_ONE  = 32'sh1000_0000;
	localparam logic signed [X_W-1:0] X_TWO  = 32'sh2000_0000;
	localparam logic signed [X_W-1:0] X_TINY = 32'sh0010_0000;

	class series_scoreboard;
		logic [THR_W-1:0] threshold;
		logic [LIM_W-1:0] term_limit;
		res_t             pending[$];
		int               errors;

		function new();
			threshold  = THR_RESET;
			term_limit = LIM_RESET;
			errors     = 0;
		endfunction

		function void write_reg(logic idx, logic [CFG_W-1:0] data);
			if (idx == REG_THRESHOLD)
				threshold = data[THR_W-1:0];
			else
				term_limit = data[LIM_W-1:0];
		endfunction

		function logic [63:0] magnitude(logic signed [63:0] v);
			logic [63:0] m;
			m = v;
			if (v[63])
				m = ~m + 64'd1;
			return m;
		endfunction

		// exact product, magnitude truncated by sh, clamped to +-(2^63-1)
		function logic signed [63:0] mul_scaled(logic signed [63:0] a, logic signed [63:0] b,
				int sh, inout bit ovf);
			logic [127:0]       prod;
			logic [63:0]        m;
			logic signed [63:0] r;
			prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
			prod = prod >> sh;
			if (prod[127:63] != '0) begin
				ovf = 1'b1;
				m   = SUM_MAX;
			end else begin
				m = prod[63:0];
			end
			r = m;
			if (a[63] != b[63])
				r = -r;
			return r;
		endfunction

		function logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b,
				inout bit ovf);
			logic signed [64:0] s;
			s = 65'(a) + 65'(b);
			if (s > SUM_MAX) begin
				ovf = 1'b1;
				return SUM_MAX;
			end
			if (s < SUM_MIN) begin
				ovf = 1'b1;
				return SUM_MIN;
			end
			return s[63:0];
		endfunction

		function logic signed [63:0] reciprocal(logic [63:0] d);
			return ((64'd1 << RECIP_BITS) + d / 64'd2) / d;
		endfunction

		function logic signed [63:0] eval_series(logic [CMD_W-1:0] kind,
				logic signed [63:0] xv, inout bit ovf);
			logic signed [63:0] x2, cur, acc, t;
			logic [63:0]        i;
			int                 lim;
			x2  = mul_scaled(xv, xv, FRAC_BITS_DEF, ovf);
			cur = (kind == CMD_SIN) ? xv : ONE_Q;
			acc = cur;
			lim = int'(term_limit);
			if (lim == 0)
				lim = 1;
			if (lim > MAX_TERMS_DEF)
				lim = MAX_TERMS_DEF;
			for (int n = 1; n < lim; n++) begin
				if (kind == CMD_EXP) begin
					t   = mul_scaled(cur, xv, FRAC_BITS_DEF, ovf);
					cur = mul_scaled(t, reciprocal(64'(n)), RECIP_BITS, ovf);
				end else begin
					i   = (kind == CMD_SIN) ? 64'(2 * n + 1) : 64'(2 * n);
					t   = mul_scaled(cur, x2, FRAC_BITS_DEF, ovf);
					cur = mul_scaled(t, reciprocal(i * (i - 64'd1)), RECIP_BITS, ovf);
					cur = -cur;
				end
				// first term below threshold ends the series, unsummed
				if (magnitude(cur) < 64'(threshold))
					break;
				acc = sat_add(acc, cur, ovf);
			end
			return acc;
		endfunction

		function void note_request(req_t r);
			logic signed [63:0] xv, ep, en, sum;
			bit                 ovf;
			res_t               e;
			xv  = {{(64-X_W){r.x[X_W-1]}}, r.x};
			ovf = 1'b0;
			sum = '0;
			case (r.cmd)
				CMD_SIN, CMD_COS, CMD_EXP: sum = eval_series(r.cmd, xv, ovf);
				CMD_SINH, CMD_COSH: begin
					ep = eval_series(CMD_EXP, xv, ovf);
					en = eval_series(CMD_EXP, -xv, ovf);
					if (r.cmd == CMD_SINH)
						en = -en;
					sum = sat_add(ep, en, ovf);
					sum = sum / 64'sd2;
				end
				default: sum = '0;
			endcase
			if (sum > OUT_HI) begin
				sum = OUT_HI;
				ovf = 1'b1;
			end else if (sum < OUT_LO) begin
				sum = OUT_LO;
				ovf = 1'b1;
			end
			e.value     = sum[VAL_W-1:0];
			e.saturated = ovf;
			pending.push_back(e);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("unexpected result: value %0d saturated %0b",
						got.value, got.saturated);
				return;
			end
			want = pending.pop_front();
			if (got.value !== want.value || got.saturated !== want.saturated) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("mismatch: value exp %0d got %0d, saturated exp %0b got %0b",
						want.value, got.value, want.saturated, got.saturated);
			end
		endfunction
	endclass

	logic             clk     = 1'b0;
	logic             arst_n  = 1'b0;
	logic             wr_en   = 1'b0;
	logic             wr_idx  = 1'b0;
	logic [CFG_W-1:0] wr_data = '0;
	logic             start   = 1'b0;
	req_t             req     = '0;
	logic             busy;
	logic             done;
	res_t             result;

	series_scoreboard sb = new();
	int               n_sent = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	taylor_series_transcendental i_dut (
		.clk,
		.arst_n,
		.wr_en,
		.wr_idx,
		.wr_data,
		.start,
		.busy,
		.req,
		.done,
		.result
	);

	// values seen here are the ones from before the edge
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		wr_en   <= 1'b1;
		wr_idx  <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	// drop start, let everything in flight come back, then reprogram
	task automatic set_registers(logic [THR_W-1:0] thr, logic [CFG_W-1:0] lim_data);
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_LIMIT, lim_data);
	endtask

	// start may stay high from the previous request; only one update per step
	task automatic send_request(req_t r);
		int gap_pct;
		bit go;
		gap_pct = (n_sent < N_ITEMS / 3) ? 24 : (n_sent < 2 * N_ITEMS / 3) ? 53 : 0;
		go      = $urandom_range(99) >= gap_pct;
		req   <= r;
		start <= go;
		@(posedge clk);
		while (!(go && !busy)) begin
			go = $urandom_range(99) >= gap_pct;
			start <= go;
			@(posedge clk);
		end
		sb.note_request(r);
		n_sent++;
	endtask

	function automatic req_t mk_req(logic [CMD_W-1:0] c, logic signed [X_W-1:0] xv);
		req_t r;
		r.cmd = c;
		r.x   = xv;
		return r;
	endfunction

	// limit word with random junk above the 7 used bits
	function automatic logic [CFG_W-1:0] lim_word(int lim);
		logic [CFG_W-1:0] w;
		w = CFG_W'($urandom);
		w[LIM_W-1:0] = LIM_W'(lim);
		return w;
	endfunction

	function automatic logic [THR_W-1:0] rand_threshold();
		return $urandom_range(1) ? THR_W'($urandom_range(255))
		                         : THR_W'($urandom_range(16'hFFFF));
	endfunction

	// mostly |x| <= 2 so series converge early; some full-range and edge values
	function automatic req_t rand_request();
		req_t                  r;
		logic signed [X_W-1:0] xv;
		int                    pick;
		pick = $urandom_range(19);
		if (pick < 3) begin
			xv = $urandom;
		end else begin
			if (pick < 13)
				xv = $urandom_range(X_TWO);
			else if (pick < 17)
				xv = $urandom_range(X_TINY);
			else begin
				case ($urandom_range(5))
					0: xv = '0;
					1: xv = X_MAX;
					2: xv = X_MIN;
					3: xv = X_ONE;
					4: xv = 32'sd1;
					default: xv = X_ONE >>> 1;
				endcase
			end
			if ($urandom_range(1))
				xv = -xv;
		end
		if ($urandom_range(9) == 0)
			r.cmd = CMD_W'($urandom_range(2**CMD_W - 1, CMD_COSH + 1));
		else
			r.cmd = CMD_W'($urandom_range(CMD_COSH));
		r.x = xv;
		return r;
	endfunction

	task automatic send_random(int count);
		repeat (count)
			send_request(rand_request());
	endtask

	initial begin
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;

		set_registers(THR_RESET, CFG_W'(LIM_RESET));
		// every selector code at zero, then argument extremes per function
		for (int c = 0; c < 2**CMD_W; c++)
			send_request(mk_req(CMD_W'(c), '0));
		for (int c = int'(CMD_SIN); c <= int'(CMD_COSH); c++) begin
			send_request(mk_req(CMD_W'(c), X_MAX));
			send_request(mk_req(CMD_W'(c), X_MIN));
		end
		send_request(mk_req(CMD_SIN, X_ONE));
		send_request(mk_req(CMD_COS, -X_ONE));
		send_request(mk_req(CMD_EXP, X_ONE));
		send_request(mk_req(CMD_SINH, -32'sd1));
		send_request(mk_req(CMD_COSH, 32'sd1));
		send_request(mk_req(CMD_W'(2**CMD_W - 1), X_MAX));
		send_random(200);

		// zero threshold, single term
		set_registers('0, lim_word(1));
		send_random(300);

		set_registers('1, lim_word(MAX_TERMS_DEF));
		send_random(250);

		// limit of zero acts as one
		set_registers(rand_threshold(), lim_word(0));
		send_random(250);

		// limit above the maximum is clipped; full-length series
		set_registers('0, lim_word(2**LIM_W - 1));
		send_random(60);

		repeat (6) begin
			set_registers(rand_threshold(), lim_word($urandom_range(24, 2)));
			send_random(75);
		end

		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+design
design/tst_pkg.sv
design/tst_mul.sv
design/tst_recip.sv
design/taylor_series_transcendental.sv
design/tst_checker.sv
test/tb.sv
